// ===== sv/owm_pkg.sv =====
package owm_pkg;

  localparam int TICK_CNT_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_SLOT     = 3'd3,
    PH_WHOLD    = 3'd4,
    PH_RREL     = 3'd5,
    PH_RTAIL    = 3'd6,
    PH_REC      = 3'd7
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_START  = 3'd0,
    REG_WRITE_HOLD  = 3'd1,
    REG_READ_SAMPLE = 3'd2,
    REG_READ_TAIL   = 3'd3,
    REG_RESET_LOW   = 3'd4,
    REG_RESET_WAIT  = 3'd5,
    REG_RECOVERY    = 3'd6
  } reg_idx_t;

  localparam logic [3:0] SLOT_START_RST  = 4'd2;
  localparam logic [6:0] WRITE_HOLD_RST  = 7'd45;
  localparam logic [4:0] READ_SAMPLE_RST = 5'd4;
  localparam logic [6:0] READ_TAIL_RST   = 7'd65;
  localparam logic [9:0] RESET_LOW_RST   = 10'd490;
  localparam logic [9:0] RESET_WAIT_RST  = 10'd580;
  localparam logic [3:0] RECOVERY_RST    = 4'd1;

  localparam logic [7:0] CRC_POLY = 8'h8c;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] last_byte;
    logic [7:0] crc_value;
  } out_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/one_wire_master_byte_engine_core.sv =====
// 1-Wire bus master byte engine. Every input item is one timing tick (normally one
// microsecond) and yields exactly one result item: the bus drive level for that tick,
// busy and done flags, the last byte read and the running Dallas CRC-8 over bytes read
// since the last reset pulse. A reset, write-byte or read-byte command is taken only
// while idle and starts in the same tick; bytes go LSB first, a read samples the line
// in the first tick of each slot tail, and every bit slot ends with a recovery gap.
// Tick counts come from seven configuration registers (a zero count acts as one).
// The engine takes one tick per clock cycle: the next state and the result are formed
// in one pass from the state registers and the tick, and the result is held in an
// output register, so a tick can be accepted every cycle while out_ready stays high.
module one_wire_master_byte_engine_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  owm_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output owm_pkg::out_item_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [3:0] slot_start_r;
  logic [6:0] write_hold_r;
  logic [4:0] read_sample_r;
  logic [6:0] read_tail_r;
  logic [9:0] reset_low_r;
  logic [9:0] reset_wait_r;
  logic [3:0] recovery_r;

  owm_pkg::phase_t phase_r, phase_nxt;
  owm_pkg::op_t    kind_r, kind_nxt;
  logic [owm_pkg::TICK_CNT_W-1:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic                  out_valid_r;
  owm_pkg::out_item_t    out_data_r, res_nxt;
  logic                  in_fire;

  logic [owm_pkg::TICK_CNT_W-1:0] len_raw, len;
  logic [owm_pkg::TICK_CNT_W:0]   tick_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_start_r  <= owm_pkg::SLOT_START_RST;
      write_hold_r  <= owm_pkg::WRITE_HOLD_RST;
      read_sample_r <= owm_pkg::READ_SAMPLE_RST;
      read_tail_r   <= owm_pkg::READ_TAIL_RST;
      reset_low_r   <= owm_pkg::RESET_LOW_RST;
      reset_wait_r  <= owm_pkg::RESET_WAIT_RST;
      recovery_r    <= owm_pkg::RECOVERY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        owm_pkg::REG_SLOT_START:  slot_start_r  <= cfg_data[3:0];
        owm_pkg::REG_WRITE_HOLD:  write_hold_r  <= cfg_data[6:0];
        owm_pkg::REG_READ_SAMPLE: read_sample_r <= cfg_data[4:0];
        owm_pkg::REG_READ_TAIL:   read_tail_r   <= cfg_data[6:0];
        owm_pkg::REG_RESET_LOW:   reset_low_r   <= cfg_data[9:0];
        owm_pkg::REG_RESET_WAIT:  reset_wait_r  <= cfg_data[9:0];
        owm_pkg::REG_RECOVERY:    recovery_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    crc_nxt   = crc_r;
    res_nxt   = '0;
    len_raw   = '0;
    len       = '0;
    tick_inc  = '0;

    // command start, only from idle
    if (phase_r == owm_pkg::PH_IDLE && in_data.op != owm_pkg::OP_NONE) begin
      kind_nxt = owm_pkg::op_t'(in_data.op);
      tick_nxt = '0;
      bit_nxt  = '0;
      if (in_data.op == owm_pkg::OP_RESET) begin
        crc_nxt   = '0;
        phase_nxt = owm_pkg::PH_RST_LOW;
      end else begin
        shift_nxt = (in_data.op == owm_pkg::OP_WRITE) ? in_data.data_byte : 8'd0;
        phase_nxt = owm_pkg::PH_SLOT;
      end
    end

    if (phase_nxt != owm_pkg::PH_IDLE) begin
      case (phase_nxt)
        owm_pkg::PH_RST_LOW:  len_raw = reset_low_r;
        owm_pkg::PH_RST_WAIT: len_raw = reset_wait_r;
        owm_pkg::PH_SLOT:     len_raw = owm_pkg::TICK_CNT_W'(slot_start_r);
        owm_pkg::PH_WHOLD:    len_raw = owm_pkg::TICK_CNT_W'(write_hold_r);
        owm_pkg::PH_RREL:     len_raw = owm_pkg::TICK_CNT_W'(read_sample_r);
        owm_pkg::PH_RTAIL:    len_raw = owm_pkg::TICK_CNT_W'(read_tail_r);
        default:              len_raw = owm_pkg::TICK_CNT_W'(recovery_r);
      endcase
      len = (len_raw == '0) ? owm_pkg::TICK_CNT_W'(1) : len_raw;
      res_nxt.busy_res = 1'b1;

      case (phase_nxt)
        owm_pkg::PH_RST_LOW: res_nxt.drive_low = 1'b1;
        owm_pkg::PH_SLOT:    res_nxt.drive_low = 1'b1;
        owm_pkg::PH_WHOLD:   res_nxt.drive_low = !shift_nxt[0];
        owm_pkg::PH_RTAIL: begin
          if (tick_nxt == '0) begin
            shift_nxt = {in_data.line_in, shift_nxt[7:1]};
          end
        end
        default: ;
      endcase

      tick_inc = {1'b0, tick_nxt} + 1'b1;
      if (tick_inc >= {1'b0, len}) begin
        tick_nxt = '0;
        case (phase_nxt)
          owm_pkg::PH_RST_LOW:  phase_nxt = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: begin
            phase_nxt        = owm_pkg::PH_IDLE;
            res_nxt.done_res = 1'b1;
          end
          owm_pkg::PH_SLOT: begin
            phase_nxt = (kind_nxt == owm_pkg::OP_WRITE) ? owm_pkg::PH_WHOLD
                                                        : owm_pkg::PH_RREL;
          end
          owm_pkg::PH_WHOLD: begin
            shift_nxt = {1'b0, shift_nxt[7:1]};
            phase_nxt = owm_pkg::PH_REC;
          end
          owm_pkg::PH_RREL:  phase_nxt = owm_pkg::PH_RTAIL;
          owm_pkg::PH_RTAIL: phase_nxt = owm_pkg::PH_REC;
          default: begin
            if (bit_nxt == 3'd7) begin
              if (kind_nxt == owm_pkg::OP_READ) begin
                rx_nxt  = shift_nxt;
                crc_nxt = owm_pkg::crc8_byte(crc_nxt, shift_nxt);
              end
              bit_nxt          = '0;
              phase_nxt        = owm_pkg::PH_IDLE;
              res_nxt.done_res = 1'b1;
            end else begin
              bit_nxt   = bit_nxt + 3'd1;
              phase_nxt = owm_pkg::PH_SLOT;
            end
          end
        endcase
      end else begin
        tick_nxt = tick_inc[owm_pkg::TICK_CNT_W-1:0];
      end
    end

    res_nxt.last_byte = rx_nxt;
    res_nxt.crc_value = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owm_pkg::PH_IDLE;
      kind_r      <= owm_pkg::OP_NONE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        rx_r    <= rx_nxt;
        crc_r   <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ===== sv/owm_checker.sv =====
module owm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input owm_pkg::out_item_t             out_data
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new tick while the result register is full and stalled
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("tick taken while result stalled");

  // done and bus drive only happen inside a command
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_res || out_data.drive_low) |-> out_data.busy_res)
    else $error("done or drive outside a command");

  // each accepted tick gives a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick without result");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind one_wire_master_byte_engine_core owm_checker u_owm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import owm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int LONG_HOLD = 300;

  class tick_scoreboard;
    logic [3:0]  slot_start;
    logic [6:0]  write_hold;
    logic [4:0]  read_sample;
    logic [6:0]  read_tail;
    logic [9:0]  reset_low, reset_wait;
    logic [3:0]  recovery;
    phase_t      phase;
    op_t         kind;
    int unsigned ticks;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  rx_byte;
    logic [7:0]  crc;
    out_item_t   expected_ticks[$];
    int          mismatches;

    function new();
      mismatches = 0;
      reset_state();
    endfunction

    function void reset_state();
      slot_start  = SLOT_START_RST;
      write_hold  = WRITE_HOLD_RST;
      read_sample = READ_SAMPLE_RST;
      read_tail   = READ_TAIL_RST;
      reset_low   = RESET_LOW_RST;
      reset_wait  = RESET_WAIT_RST;
      recovery    = RECOVERY_RST;
      phase = PH_IDLE;
      kind = OP_NONE;
      ticks = 0;
      bit_idx = '0;
      shreg = '0;
      rx_byte = '0;
      crc = '0;
      expected_ticks.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SLOT_START:  slot_start  = v[3:0];
        REG_WRITE_HOLD:  write_hold  = v[6:0];
        REG_READ_SAMPLE: read_sample = v[4:0];
        REG_READ_TAIL:   read_tail   = v[6:0];
        REG_RESET_LOW:   reset_low   = v[9:0];
        REG_RESET_WAIT:  reset_wait  = v[9:0];
        REG_RECOVERY:    recovery    = v[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned phase_ticks(phase_t ph);
      int unsigned v;
      case (ph)
        PH_RST_LOW:  v = 32'(reset_low);
        PH_RST_WAIT: v = 32'(reset_wait);
        PH_SLOT:     v = 32'(slot_start);
        PH_WHOLD:    v = 32'(write_hold);
        PH_RREL:     v = 32'(read_sample);
        PH_RTAIL:    v = 32'(read_tail);
        default:     v = 32'(recovery);
      endcase
      if (v == 0) v = 1;
      if (v > (1 << TICK_CNT_W)) v = 1 << TICK_CNT_W;
      return v;
    endfunction

    function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function out_item_t predict_tick(in_item_t it);
      out_item_t   r;
      int unsigned len;
      op_t         op;
      r = '0;
      op = op_t'(it.op);
      if (phase == PH_IDLE && op != OP_NONE) begin
        kind = op;
        ticks = 0;
        bit_idx = '0;
        if (op == OP_RESET) begin
          crc = '0;
          phase = PH_RST_LOW;
        end else begin
          shreg = (op == OP_WRITE) ? it.data_byte : 8'h00;
          phase = PH_SLOT;
        end
      end
      if (phase != PH_IDLE) begin
        len = phase_ticks(phase);
        r.busy_res = 1'b1;
        case (phase)
          PH_RST_LOW, PH_SLOT: r.drive_low = 1'b1;
          PH_WHOLD: r.drive_low = ~shreg[0];
          PH_RTAIL: if (ticks == 0) shreg = {it.line_in, shreg[7:1]};
          default: ;
        endcase
        ticks++;
        if (ticks >= len) begin
          ticks = 0;
          case (phase)
            PH_RST_LOW:  phase = PH_RST_WAIT;
            PH_RST_WAIT: begin
              phase = PH_IDLE;
              r.done_res = 1'b1;
            end
            PH_SLOT:  phase = (kind == OP_WRITE) ? PH_WHOLD : PH_RREL;
            PH_WHOLD: begin
              shreg = shreg >> 1;
              phase = PH_REC;
            end
            PH_RREL:  phase = PH_RTAIL;
            PH_RTAIL: phase = PH_REC;
            default: begin
              if (bit_idx == 3'd7) begin
                if (kind == OP_READ) begin
                  rx_byte = shreg;
                  crc = crc_step(crc, rx_byte);
                end
                bit_idx = '0;
                phase = PH_IDLE;
                r.done_res = 1'b1;
              end else begin
                bit_idx = bit_idx + 3'd1;
                phase = PH_SLOT;
              end
            end
          endcase
        end
      end
      r.last_byte = rx_byte;
      r.crc_value = crc;
      return r;
    endfunction

    function void note_tick(in_item_t it);
      expected_ticks.push_back(predict_tick(it));
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_tick(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = expected_ticks.pop_front();
        if (got.drive_low !== want.drive_low)
          report($sformatf("drive_low %b, expected %b", got.drive_low, want.drive_low));
        if (got.busy_res !== want.busy_res)
          report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
        if (got.last_byte !== want.last_byte)
          report($sformatf("last_byte %h, expected %h", got.last_byte, want.last_byte));
        if (got.crc_value !== want.crc_value)
          report($sformatf("crc_value %h, expected %h", got.crc_value, want.crc_value));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tick_scoreboard        sb;
  logic [CFG_DATA_W-1:0] cfg_vals [7];
  int                    burst_left = 0;
  int                    fed = 0;
  int                    hold_requests = 0;

  one_wire_master_byte_engine_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tick(out_data);
  end

  // receiver: stall modes that change over time, plus requested long holds
  initial begin
    int mode;
    int left;
    int holds_done;
    mode = 0;
    left = 0;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(40, 200);
      end
      left--;
      @(negedge clk);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (left % 5 != 0);
      endcase
    end
  end

  task automatic drive_tick(input op_t op, input logic [7:0] d, input logic ln);
    in_item_t it;
    bit       ignored;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20) : $urandom_range(50, 200);
    end
    burst_left--;
    it.op = op;
    it.data_byte = d;
    it.line_in = ln;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    ignored = (sb.phase != PH_IDLE) && (op != OP_NONE);
    sb.note_tick(it);
    if (!ignored) fed++;
  endtask

  // line level for the next tick: the pattern bit at the sampling tick of a read
  function automatic logic line_bit(input logic [7:0] pat, input int flip_pct);
    logic b;
    if (sb.phase == PH_RTAIL && sb.ticks == 0) b = pat[sb.bit_idx];
    else b = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < flip_pct) b = ~b;
    return b;
  endfunction

  task automatic settle();
    while (sb.phase != PH_IDLE) drive_tick(OP_NONE, 8'($urandom), line_bit(8'h00, 50));
  endtask

  task automatic run_command(input op_t op, input logic [7:0] d, input logic [7:0] pat,
                             input int noise_pct);
    op_t nop;
    settle();
    drive_tick(op, d, 1'($urandom_range(0, 1)));
    while (sb.phase != PH_IDLE) begin
      nop = OP_NONE;
      if ($urandom_range(0, 99) < noise_pct) nop = op_t'($urandom_range(1, 3));
      drive_tick(nop, 8'($urandom), line_bit(pat, noise_pct));
    end
  endtask

  task automatic write_config(input bit with_spare);
    logic [CFG_DATA_W-1:0] v;
    settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      if (i < 7 || with_spare) begin
        v = (i < 7) ? cfg_vals[i] : CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= (i < 7) ? reg_idx_t'(i) : REG_SPARE;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg((i < 7) ? reg_idx_t'(i) : REG_SPARE, v);
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] rom [9];
    logic [7:0] c;
    int         budget;
    int         w;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default timing
    repeat (3) drive_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
    run_command(OP_WRITE, 8'h5a, 8'h00, 0);

    // zero counts act as one tick
    foreach (cfg_vals[i]) cfg_vals[i] = '0;
    write_config(1'b0);
    run_command(OP_WRITE, 8'ha5, 8'h00, 0);
    run_command(OP_READ, 8'h00, 8'h5a, 0);
    run_command(OP_RESET, 8'h00, 8'h00, 0);
    // commands while busy, including the done tick, are dropped
    repeat (40) drive_tick(op_t'($urandom_range(1, 3)), 8'($urandom),
                           1'($urandom_range(0, 1)));
    settle();

    // nine bytes whose crc comes out zero
    foreach (cfg_vals[i]) cfg_vals[i] = 10'd1;
    write_config(1'b0);
    c = '0;
    for (int k = 0; k < 8; k++) begin
      rom[k] = 8'($urandom);
      c = sb.crc_step(c, rom[k]);
    end
    rom[8] = c;
    run_command(OP_RESET, 8'h00, 8'h00, 0);
    for (int k = 0; k < 9; k++) run_command(OP_READ, 8'($urandom), rom[k], 0);
    run_command(OP_READ, 8'($urandom), 8'($urandom), 0);

    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 7; i++) begin
        if (p == 3) begin
          w = (i == REG_RESET_LOW || i == REG_RESET_WAIT) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 1023);
        end else begin
          w = (i == REG_RESET_LOW || i == REG_RESET_WAIT) ? $urandom_range(0, 12)
                                                          : $urandom_range(0, 4);
          // junk in the bits above the register width on odd settings
          if (p % 2 == 1 && i != REG_RESET_LOW && i != REG_RESET_WAIT)
            w = w | int'($urandom & 10'h380);
        end
        cfg_vals[i] = CFG_DATA_W'(w);
      end
      write_config(1'($urandom_range(0, 1)));
      if (p == 1) hold_requests++;
      budget = fed + ((p == 3) ? 1 : 120);
      while (fed < budget) begin
        if ($urandom_range(0, 99) < 85) begin
          run_command(op_t'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 8);
        end else begin
          repeat ($urandom_range(1, 10))
            drive_tick(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
        end
      end
      settle();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
